// ----- design/sog_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the strided offset generator.
package sog_pkg;

    localparam int unsigned MAX_DIMS_DEF = 8;
    localparam int unsigned IDX_W        = 32;
    localparam int unsigned SIZE_W       = 16;
    localparam int unsigned STRIDE_W     = 32;
    localparam int unsigned PROD_W       = SIZE_W + STRIDE_W;
    localparam int unsigned OFFS_W       = 51;
    localparam int unsigned CFG_W        = 64;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned NDIMS_W      = 4;
    localparam int unsigned DIV_STEP     = 4;
    localparam int unsigned DIV_STAGES   = IDX_W / DIV_STEP;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_DIMS   = 3'd0,
        REG_SIZES_LO   = 3'd1,
        REG_SIZES_HI   = 3'd2,
        REG_STRIDES_01 = 3'd3,
        REG_STRIDES_23 = 3'd4,
        REG_STRIDES_45 = 3'd5,
        REG_STRIDES_67 = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic                active;
        logic [SIZE_W-1:0]   size;
        logic [STRIDE_W-1:0] stride;
    } t_dim_cfg;

    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [IDX_W-1:0]  q;
        logic [OFFS_W-1:0] offset;
    } t_div_data;

    typedef struct packed {
        logic [IDX_W-1:0]  curr;
        logic [OFFS_W-1:0] offset;
    } t_dim_data;

endpackage

// ----- design/sog_div_stage.sv -----
`timescale 1ns / 1ps
// One registered stage of the restoring divider, DIV_STEP quotient bits.
module sog_div_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  sog_pkg::t_div_data          i_data,
    input  logic [sog_pkg::SIZE_W-1:0]  i_divisor,
    output logic                        o_valid,
    output sog_pkg::t_div_data          o_data
);
    import sog_pkg::*;

    logic              r_valid;
    t_div_data         r_data;
    t_div_data         n_data;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W-1:0] rem;
    logic [IDX_W-1:0]  q;

    always_comb begin
        rem   = i_data.rem;
        q     = i_data.q;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {rem, q[IDX_W-1]};
            q     = {q[IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                rem  = SIZE_W'(trial - {1'b0, i_divisor});
                q[0] = 1'b1;
            end else begin
                rem = trial[SIZE_W-1:0];
            end
        end
        n_data.rem    = rem;
        n_data.q      = q;
        n_data.offset = i_data.offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- design/sog_dim.sv -----
`timescale 1ns / 1ps
// One dimension: pipelined divide, remainder times stride, accumulate.
module sog_dim (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sog_pkg::t_dim_cfg  i_cfg,
    input  logic               i_valid,
    input  sog_pkg::t_dim_data i_data,
    output logic               o_valid,
    output sog_pkg::t_dim_data o_data
);
    import sog_pkg::*;

    logic              div_valid [DIV_STAGES+1];
    t_div_data         div_data  [DIV_STAGES+1];
    logic [SIZE_W-1:0] divisor;

    logic              r_mul_valid;
    logic [IDX_W-1:0]  r_mul_q;
    logic [PROD_W-1:0] r_mul_prod;
    logic [OFFS_W-1:0] r_mul_offset;
    logic [PROD_W-1:0] n_mul_prod;

    logic              r_out_valid;
    t_dim_data         r_out;
    t_dim_data         n_out;

    assign divisor = (i_cfg.size == '0) ? SIZE_W'(1) : i_cfg.size;

    assign div_valid[0]       = i_valid;
    assign div_data[0].rem    = '0;
    assign div_data[0].q      = i_data.curr;
    assign div_data[0].offset = i_data.offset;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        sog_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (div_valid[s]),
            .i_data    (div_data[s]),
            .i_divisor (divisor),
            .o_valid   (div_valid[s+1]),
            .o_data    (div_data[s+1])
        );
    end

    assign n_mul_prod = i_cfg.active ?
        PROD_W'(div_data[DIV_STAGES].rem) * PROD_W'(i_cfg.stride) : '0;

    assign n_out.curr   = r_mul_q;
    assign n_out.offset = r_mul_offset + OFFS_W'(r_mul_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_valid <= div_valid[DIV_STAGES];
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_q      <= div_data[DIV_STAGES].q;
        r_mul_prod   <= n_mul_prod;
        r_mul_offset <= div_data[DIV_STAGES].offset;
        r_out        <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

// ----- design/strided_offset_generator.sv -----
`timescale 1ns / 1ps
// Top level of the strided offset generator: registers and dimension chain.
//  channel  | ports                                  | transfer when
//  command  | i_start, o_busy, i_linear_index        | i_start high, o_busy low
//  result   | o_strobe, o_source_offset              | o_strobe high
//  config   | i_cfg_wr_en, i_cfg_index, i_cfg_data   | i_cfg_wr_en high
// One item enters per cycle; o_busy stays low.
// The chain holds MAX_DIMS dimensions; each dimension
// holds an 8-stage radix-16 divider, a multiply stage and an add stage.
// Synchronous reset clears the registers to their defaults and the valid bits.
// The receiver cannot stall; results leave on the strobe cycle.
module strided_offset_generator #(
    parameter int unsigned MAX_DIMS = sog_pkg::MAX_DIMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [sog_pkg::IDX_W-1:0]      i_linear_index,
    output logic                           o_strobe,
    output logic [sog_pkg::OFFS_W-1:0]     o_source_offset,
    input  logic                           i_cfg_wr_en,
    input  logic [sog_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sog_pkg::CFG_W-1:0]      i_cfg_data
);
    import sog_pkg::*;

    logic [NDIMS_W-1:0]  r_num_dims;
    logic [CFG_W-1:0]    r_sizes_lo;
    logic [CFG_W-1:0]    r_sizes_hi;
    logic [CFG_W-1:0]    r_strides [4];

    logic [NDIMS_W-1:0]  n_sat;
    logic [SIZE_W-1:0]   sizes   [8];
    logic [STRIDE_W-1:0] strides [8];
    t_dim_cfg            dim_cfg [MAX_DIMS];

    logic                chain_valid [MAX_DIMS+1];
    t_dim_data           chain_data  [MAX_DIMS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NDIMS_W'(1);
            r_sizes_lo <= CFG_W'(1);
            r_sizes_hi <= '0;
            r_strides[0] <= CFG_W'(1);
            r_strides[1] <= '0;
            r_strides[2] <= '0;
            r_strides[3] <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_NUM_DIMS:   r_num_dims   <= i_cfg_data[NDIMS_W-1:0];
                REG_SIZES_LO:   r_sizes_lo   <= i_cfg_data;
                REG_SIZES_HI:   r_sizes_hi   <= i_cfg_data;
                REG_STRIDES_01: r_strides[0] <= i_cfg_data;
                REG_STRIDES_23: r_strides[1] <= i_cfg_data;
                REG_STRIDES_45: r_strides[2] <= i_cfg_data;
                REG_STRIDES_67: r_strides[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar d = 0; d < 4; d++) begin : g_unpack
        assign sizes[d]       = r_sizes_lo[d*SIZE_W +: SIZE_W];
        assign sizes[d+4]     = r_sizes_hi[d*SIZE_W +: SIZE_W];
        assign strides[2*d]   = r_strides[d][0 +: STRIDE_W];
        assign strides[2*d+1] = r_strides[d][STRIDE_W +: STRIDE_W];
    end

    assign n_sat = (r_num_dims > NDIMS_W'(MAX_DIMS)) ? NDIMS_W'(MAX_DIMS) : r_num_dims;

    assign chain_valid[0]       = i_start;
    assign chain_data[0].curr   = i_linear_index;
    assign chain_data[0].offset = '0;

    for (genvar j = 0; j < MAX_DIMS; j++) begin : g_dim
        logic [NDIMS_W-1:0] sel;
        assign sel = n_sat - NDIMS_W'(j + 1);
        assign dim_cfg[j].active = (NDIMS_W'(j) < n_sat);
        assign dim_cfg[j].size   = sizes[sel[2:0]];
        assign dim_cfg[j].stride = strides[sel[2:0]];

        sog_dim u_dim (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (dim_cfg[j]),
            .i_valid (chain_valid[j]),
            .i_data  (chain_data[j]),
            .o_valid (chain_valid[j+1]),
            .o_data  (chain_data[j+1])
        );
    end

    assign o_busy          = 1'b0;
    assign o_strobe        = chain_valid[MAX_DIMS];
    assign o_source_offset = chain_data[MAX_DIMS].offset;
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the strided offset generator: directed and random index transfers.
module tb_top;
    import sog_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int unsigned          TIMEOUT      = 3000;
    localparam int unsigned          TAIL_CYCLES  = 120;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic [IDX_W-1:0]     i_linear_index = '0;
    logic                 o_strobe;
    logic [OFFS_W-1:0]    o_source_offset;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [CFG_W-1:0]     cfg_shadow [0:6];
    logic [IDX_W-1:0]     pending_indices [$];
    logic [OFFS_W-1:0]    offsets_due [$];
    int unsigned          sender_idle_pct = 0;
    int unsigned          error_count = 0;
    int unsigned          quiet_cycles = 0;
    logic                 taken = 1'b0;

    strided_offset_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_linear_index(i_linear_index), .o_strobe(o_strobe),
        .o_source_offset(o_source_offset), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [OFFS_W-1:0] offset_of(logic [IDX_W-1:0] lin);
        logic [63:0]       curr;
        logic [63:0]       sz;
        logic [63:0]       st;
        logic [OFFS_W-1:0] acc;
        int unsigned       n;
        int unsigned       d;
        curr = 64'(lin);
        acc  = '0;
        n    = cfg_shadow[REG_NUM_DIMS][3:0];
        if (n > 8) n = 8;
        for (int k = n; k > 0; k--) begin
            d  = k - 1;
            sz = (d < 4) ? 64'(cfg_shadow[REG_SIZES_LO][d*16 +: 16])
                         : 64'(cfg_shadow[REG_SIZES_HI][(d-4)*16 +: 16]);
            if (sz == 0) sz = 1;
            st = 64'(cfg_shadow[3 + d/2][(d%2)*32 +: 32]);
            acc = acc + OFFS_W'((curr % sz) * st);
            curr = curr / sz;
        end
        return acc;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // driver: hold an unaccepted transfer, else offer the next index
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !taken) begin
            i_start <= 1'b1;
        end else if (pending_indices.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            i_start        <= 1'b1;
            i_linear_index <= pending_indices.pop_front();
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [OFFS_W-1:0] want;
        taken <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (i_start && !o_busy) offsets_due.push_back(offset_of(i_linear_index));
            if (o_strobe) begin
                if (offsets_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected offset %0h", o_source_offset));
                end else begin
                    want = offsets_due.pop_front();
                    if (o_source_offset !== want)
                        report_mismatch($sformatf("source_offset %0h, want %0h",
                                                  o_source_offset, want));
                end
            end
            if ((i_start && !o_busy) || o_strobe || i_cfg_wr_en) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= TIMEOUT) begin
                $display("strided_offset_generator: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx != REG_UNMAPPED)
            cfg_shadow[idx] = (idx == REG_NUM_DIMS) ? CFG_W'(data[3:0]) : data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_indices.size() > 0 || i_start || offsets_due.size() > 0);
    endtask

    function automatic logic [15:0] rand_size();
        int unsigned r;
        r = $urandom_range(7);
        if (r < 2) return 16'd0;
        if (r < 6) return 16'($urandom_range(1, 9));
        return 16'($urandom);
    endfunction

    initial begin
        logic [63:0] w;
        cfg_shadow[0] = 1; cfg_shadow[1] = 1; cfg_shadow[2] = 0; cfg_shadow[3] = 1;
        cfg_shadow[4] = 0; cfg_shadow[5] = 0; cfg_shadow[6] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_indices = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555};
        drain();
        write_reg(REG_NUM_DIMS, 64'd3);
        write_reg(REG_SIZES_LO, 64'h0000_0004_0000_0003);
        write_reg(REG_STRIDES_01, 64'h0000_0001_0000_0010);
        write_reg(REG_STRIDES_23, 64'h0000_0000_0000_0100);
        pending_indices = '{32'd0, 32'd1, 32'd4, 32'd11, 32'd12, 32'd13, 32'hAAAA_AAAA,
                            32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678};
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_reg(REG_NUM_DIMS, 64'd0);
                1: begin
                    write_reg(REG_NUM_DIMS, 64'd8);
                    write_reg(REG_SIZES_LO, '1);
                    write_reg(REG_SIZES_HI, '1);
                    for (int r = REG_STRIDES_01; r <= REG_STRIDES_67; r++)
                        write_reg(CFG_IDX_W'(r), '1);
                end
                2: begin
                    write_reg(REG_NUM_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(REG_SIZES_LO, 64'd0);
                    write_reg(REG_SIZES_HI, 64'd0);
                end
                default: begin
                    write_reg(REG_NUM_DIMS, {$urandom, $urandom});
                    for (int r = REG_SIZES_LO; r <= REG_SIZES_HI; r++) begin
                        w = (p == 7) ? {$urandom, $urandom}
                                     : {rand_size(), rand_size(), rand_size(), rand_size()};
                        write_reg(CFG_IDX_W'(r), w);
                    end
                    for (int r = REG_STRIDES_01; r <= REG_STRIDES_67; r++)
                        write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
                end
            endcase
            write_reg(REG_UNMAPPED, {$urandom, $urandom});
            case (p % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 82;
                2: sender_idle_pct = 7;
                default: sender_idle_pct = 50;
            endcase
            for (int i = 0; i < 215; i++)
                pending_indices.push_back($urandom_range(1) ? 32'($urandom_range(0, 4095))
                                                            : 32'($urandom));
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && offsets_due.size() == 0)
            $display("strided_offset_generator: match");
        else
            $display("strided_offset_generator: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/sog_pkg.sv
design/sog_div_stage.sv
design/sog_dim.sv
design/strided_offset_generator.sv
tb/sv/tb_top.sv
